// ----- rtl/core/pcfr_pkg.sv -----
// shared types and constants of the parity count frame receiver
`timescale 1ns / 1ps
package pcfr_pkg;

  localparam int BUF_DEPTH_DEF = 64;
  localparam int CNT_W = 7;
  localparam int CHECK_BYTES = 2;
  localparam int JOBQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;
  localparam logic [7:0] HEADER_RESET = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    JOB_DRAIN    = 2'd0,
    JOB_MISMATCH = 2'd1,
    JOB_OVERFLOW = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [CNT_W-1:0] plen;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last;
    status_t    status;
  } out_item_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_DRAIN = 1'b1
  } bk_state_t;

endpackage

// ----- rtl/core/pcfr_front.sv -----
// front end: header register, byte classification, counts and frame check
`timescale 1ns / 1ps
module pcfr_front #(
  parameter int BUF_DEPTH = pcfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_data,
  input  logic                push,
  input  logic [7:0]          rx_byte,
  output logic                full,
  input  logic                jq_full,
  output logic                jq_push,
  output pcfr_pkg::job_t      jq_job,
  input  logic                drain_done,
  output pcfr_pkg::store_wr_t store_wr
);

  logic [7:0]                 header_reg;
  logic [pcfr_pkg::CNT_W-1:0] fill;
  logic [pcfr_pkg::CNT_W-1:0] odd_cnt;
  logic [pcfr_pkg::CNT_W-1:0] even_cnt;
  logic                       overflowed;
  logic                       locked;
  logic [7:0]                 prev1;
  logic [7:0]                 prev2;

  logic       accept;
  logic       is_hdr;
  logic       at_limit;
  logic [7:0] po;
  logic [7:0] pe;
  logic       match;

  assign full     = locked || jq_full;
  assign accept   = push && !full;
  assign is_hdr   = (rx_byte == header_reg);
  assign at_limit = (fill == pcfr_pkg::CNT_W'(BUF_DEPTH));

  // prev2 is the odd check byte, prev1 the even check byte
  assign po = {1'b0, odd_cnt} - {7'd0, prev2[0]} - {7'd0, prev1[0]};
  assign pe = {1'b0, even_cnt} - {7'd0, !prev2[0]} - {7'd0, !prev1[0]};
  assign match = (prev2 == po) && (prev1 == pe);

  always_comb begin
    jq_push       = 1'b0;
    jq_job.kind   = pcfr_pkg::JOB_DRAIN;
    jq_job.plen   = fill - pcfr_pkg::CNT_W'(pcfr_pkg::CHECK_BYTES);
    store_wr.en   = accept && !is_hdr && !at_limit;
    store_wr.addr = fill;
    store_wr.data = rx_byte;
    if (accept && is_hdr) begin
      if (overflowed) begin
        jq_push     = 1'b1;
        jq_job.kind = pcfr_pkg::JOB_OVERFLOW;
      end else if (fill > pcfr_pkg::CNT_W'(pcfr_pkg::CHECK_BYTES)) begin
        jq_push     = 1'b1;
        jq_job.kind = match ? pcfr_pkg::JOB_DRAIN : pcfr_pkg::JOB_MISMATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_reg <= pcfr_pkg::HEADER_RESET;
      fill       <= '0;
      odd_cnt    <= '0;
      even_cnt   <= '0;
      overflowed <= 1'b0;
      locked     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        header_reg <= cfg_data;
      end
      if (drain_done) begin
        locked <= 1'b0;
      end
      if (accept && is_hdr) begin
        fill       <= '0;
        odd_cnt    <= '0;
        even_cnt   <= '0;
        overflowed <= 1'b0;
        if (jq_push && jq_job.kind == pcfr_pkg::JOB_DRAIN) begin
          locked <= 1'b1;
        end
      end else if (accept) begin
        if (at_limit) begin
          overflowed <= 1'b1;
        end else begin
          fill <= fill + pcfr_pkg::CNT_W'(1);
          if (rx_byte[0]) begin
            odd_cnt <= odd_cnt + pcfr_pkg::CNT_W'(1);
          end else begin
            even_cnt <= even_cnt + pcfr_pkg::CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      prev2 <= prev1;
      prev1 <= rx_byte;
    end
  end

endmodule

// ----- rtl/core/pcfr_jobq.sv -----
// short queue of frame jobs between front and back
`timescale 1ns / 1ps
module pcfr_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pcfr_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pcfr_pkg::job_t dout
);

  localparam int PW = $clog2(pcfr_pkg::JOBQ_DEPTH);
  localparam int CW = $clog2(pcfr_pkg::JOBQ_DEPTH + 1);

  pcfr_pkg::job_t entries [pcfr_pkg::JOBQ_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(pcfr_pkg::JOBQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(pcfr_pkg::JOBQ_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(pcfr_pkg::JOBQ_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= din;
    end
  end

endmodule

// ----- rtl/core/pcfr_back.sv -----
// back end: frame store, drain sequencer and result queue
`timescale 1ns / 1ps
module pcfr_back #(
  parameter int BUF_DEPTH = pcfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pcfr_pkg::store_wr_t  store_wr,
  input  logic                 job_valid,
  input  pcfr_pkg::job_t       job,
  output logic                 job_pop,
  output logic                 drain_done,
  input  logic                 pop,
  output logic                 empty,
  output pcfr_pkg::out_item_t  item
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int QP = $clog2(pcfr_pkg::OQ_DEPTH);
  localparam int QC = $clog2(pcfr_pkg::OQ_DEPTH + 1);

  logic [7:0] store [BUF_DEPTH];

  pcfr_pkg::bk_state_t        state;
  pcfr_pkg::bk_state_t        state_next;
  logic [pcfr_pkg::CNT_W-1:0] idx;
  logic [pcfr_pkg::CNT_W-1:0] idx_next;
  logic [pcfr_pkg::CNT_W-1:0] plen;
  logic [pcfr_pkg::CNT_W-1:0] plen_next;
  logic                       rd_pending;
  logic                       rd_last;
  logic [7:0]                 rd_data;

  pcfr_pkg::out_item_t oq [pcfr_pkg::OQ_DEPTH];
  logic [QP-1:0]       oq_wptr;
  logic [QP-1:0]       oq_rptr;
  logic [QC-1:0]       oq_count;

  logic                       rd_issue;
  logic                       issue_last;
  logic                       err_push;
  pcfr_pkg::status_t          err_status;
  logic                       space;
  logic                       oq_push;
  logic                       oq_pop;
  pcfr_pkg::out_item_t        push_item;
  logic [pcfr_pkg::CNT_W-1:0] idx_inc;

  assign space   = ({1'b0, oq_count} + {{QC{1'b0}}, rd_pending})
                   < (QC + 1)'(pcfr_pkg::OQ_DEPTH);
  assign idx_inc = idx + pcfr_pkg::CNT_W'(1);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    plen_next  = plen;
    job_pop    = 1'b0;
    rd_issue   = 1'b0;
    issue_last = 1'b0;
    drain_done = 1'b0;
    err_push   = 1'b0;
    err_status = pcfr_pkg::ST_MISMATCH;
    unique case (state)
      pcfr_pkg::BK_IDLE: begin
        if (job_valid && !rd_pending) begin
          unique case (job.kind)
            pcfr_pkg::JOB_DRAIN: begin
              job_pop    = 1'b1;
              idx_next   = '0;
              plen_next  = job.plen;
              state_next = pcfr_pkg::BK_DRAIN;
            end
            pcfr_pkg::JOB_MISMATCH: begin
              if (space) begin
                job_pop  = 1'b1;
                err_push = 1'b1;
              end
            end
            pcfr_pkg::JOB_OVERFLOW: begin
              if (space) begin
                job_pop    = 1'b1;
                err_push   = 1'b1;
                err_status = pcfr_pkg::ST_OVERFLOW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pcfr_pkg::BK_DRAIN: begin
        if (space) begin
          rd_issue = 1'b1;
          idx_next = idx_inc;
          if (idx_inc == plen) begin
            issue_last = 1'b1;
            drain_done = 1'b1;
            state_next = pcfr_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = pcfr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pcfr_pkg::BK_IDLE;
      idx        <= '0;
      plen       <= '0;
      rd_pending <= 1'b0;
      rd_last    <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      plen       <= plen_next;
      rd_pending <= rd_issue;
      rd_last    <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[store_wr.addr[AW-1:0]] <= store_wr.data;
    end
    if (rd_issue) begin
      rd_data <= store[idx[AW-1:0]];
    end
  end

  // result queue
  always_comb begin
    if (rd_pending) begin
      push_item.payload_byte = rd_data;
      push_item.last         = rd_last;
      push_item.status       = pcfr_pkg::ST_OK;
    end else begin
      push_item.payload_byte = 8'd0;
      push_item.last         = 1'b1;
      push_item.status       = err_status;
    end
  end

  assign oq_push = rd_pending || err_push;
  assign empty   = (oq_count == '0);
  assign oq_pop  = pop && !empty;
  assign item    = oq[oq_rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= '0;
      oq_rptr  <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) begin
        oq_wptr <= (oq_wptr == QP'(pcfr_pkg::OQ_DEPTH - 1)) ? '0 : oq_wptr + QP'(1);
      end
      if (oq_pop) begin
        oq_rptr <= (oq_rptr == QP'(pcfr_pkg::OQ_DEPTH - 1)) ? '0 : oq_rptr + QP'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_count <= oq_count + QC'(1);
      end else if (oq_pop && !oq_push) begin
        oq_count <= oq_count - QC'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wptr] <= push_item;
    end
  end

endmodule

// ----- rtl/core/parity_count_frame_receiver.sv -----
// top level of the parity count frame receiver
`timescale 1ns / 1ps
// Takes one link byte per cycle while full is low. A byte equal to header_byte closes a
// frame: a frame whose odd/even check bytes match comes out as its payload bytes, one per
// cycle while the result queue has room, last set on the final one; a mismatch or a buffer
// overflow gives one error result; a frame of two bytes or fewer gives nothing. A checked
// frame drains through the single read port of the frame store, and the input holds full
// from its closing header until the last store read has been issued, since the next frame
// reuses the store. Error frames do not lock the input; their jobs pass through a
// two-entry job queue. Results wait in a four-entry queue, so pop may stall at will.
module parity_count_frame_receiver #(
  parameter int BUF_DEPTH = pcfr_pkg::BUF_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] header_byte,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] payload_byte,
  output logic       last,
  output logic [1:0] status
);

  logic                jq_push;
  logic                jq_full;
  logic                jq_pop;
  logic                jq_empty;
  pcfr_pkg::job_t      jq_in;
  pcfr_pkg::job_t      jq_out;
  logic                drain_done;
  pcfr_pkg::store_wr_t store_wr;
  pcfr_pkg::out_item_t item;

  assign cfg_ready    = 1'b1;
  assign payload_byte = item.payload_byte;
  assign last         = item.last;
  assign status       = item.status;

  pcfr_front #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (header_byte),
    .push       (push),
    .rx_byte    (rx_byte),
    .full       (full),
    .jq_full    (jq_full),
    .jq_push    (jq_push),
    .jq_job     (jq_in),
    .drain_done (drain_done),
    .store_wr   (store_wr)
  );

  pcfr_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (jq_push),
    .din   (jq_in),
    .full  (jq_full),
    .pop   (jq_pop),
    .empty (jq_empty),
    .dout  (jq_out)
  );

  pcfr_back #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .store_wr   (store_wr),
    .job_valid  (!jq_empty),
    .job        (jq_out),
    .job_pop    (jq_pop),
    .drain_done (drain_done),
    .pop        (pop),
    .empty      (empty),
    .item       (item)
  );

  a_jq_no_overrun: assert property (@(posedge clk) disable iff (rst)
    jq_push |-> !jq_full)
    else $error("job queue pushed while full");

  a_drain_locks_input: assert property (@(posedge clk) disable iff (rst)
    (jq_push && jq_in.kind == pcfr_pkg::JOB_DRAIN) |=> full)
    else $error("input open while a frame waits to drain");

  a_error_result_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != pcfr_pkg::ST_OK) |-> (last && payload_byte == 8'd0))
    else $error("error result not a single zero transaction");

  a_store_quiet_in_drain: assert property (@(posedge clk) disable iff (rst)
    jq_pop && jq_out.kind == pcfr_pkg::JOB_DRAIN |=> !store_wr.en)
    else $error("frame store written during drain");

endmodule
